### hdl/plt_pkg.sv
// Shared constants, codes and types of the positional list table.
`default_nettype none
package plt_pkg;

    localparam int LIST_SIZE  = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W  = $clog2(LIST_SIZE);
    localparam int CNT_W   = $clog2(LIST_SIZE + 1);
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 3;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

endpackage
`default_nettype wire

### hdl/plt_ram.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module plt_ram
    import plt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_ram_req              i_req,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [LIST_SIZE];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/positional_list_table_core.sv
// Positional list table: command sequencer around the entry store.
// Refused commands, clear and unknown codes go straight to the result; get reads one entry;
// delete, insert and locate walk the entries one at a time through the single read port,
// at most LIST_SIZE of them.
// One command is in work at a time; the next is taken once the result is registered.
// Reset clears the length and the handshake state; entry contents are not cleared.
`default_nettype none
module positional_list_table_core
    import plt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [CMD_W-1:0]   i_command,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [VAL_W-1:0]   i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [ST_W-1:0]    o_status,
    output logic      [VAL_W-1:0]   o_read_value,
    output logic      [POS_W-1:0]   o_found_position,
    output logic      [COUNT_W-1:0] o_count,
    output logic                    o_is_empty
);

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [ADDR_W-1:0]     r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [ADDR_W-1:0]     r_idx;
    logic [ADDR_W-1:0]     r_end;
    logic                  r_rv;
    logic [ADDR_W-1:0]     r_ra;
    logic [ST_W-1:0]       r_status;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [POS_W-1:0]      r_found;
    logic [CNT_W-1:0]      r_count;

    logic                  r_out_valid;
    logic [ST_W-1:0]       r_out_status;
    logic [VAL_W-1:0]      r_out_rd;
    logic [POS_W-1:0]      r_out_found;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;

    t_ram_req              w_req;
    logic [DATA_WIDTH-1:0] w_rdata;

    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic [ADDR_W-1:0]     w_first;
    logic [ADDR_W-1:0]     w_last;
    logic [ST_W-1:0]       d_status;
    t_state                d_next;
    logic [ADDR_W-1:0]     d_idx;
    logic [ADDR_W-1:0]     d_end;

    logic                  w_accept;
    logic                  w_proc;
    logic                  w_hit;
    logic                  w_load;

    plt_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_accept = i_in_valid && o_in_ready;
    assign w_proc   = r_rv && (r_state == S_WALK || r_state == S_TAIL);
    assign w_hit    = w_proc && (r_cmd == CMD_LOCATE) && (w_rdata == r_val);
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // command decode against the current length
    always_comb begin
        w_pos_x  = CMP_W'(i_position);
        w_cnt_x  = CMP_W'(r_count);
        w_first  = ADDR_W'(w_pos_x - CMP_W'(1));
        w_last   = ADDR_W'(w_cnt_x - CMP_W'(1));
        d_status = ST_OK;
        d_next   = S_DONE;
        d_idx    = w_first;
        d_end    = w_first;
        unique case (i_command)
            CMD_INSERT: begin
                if (w_pos_x == '0 || w_pos_x > w_cnt_x + CMP_W'(1)) begin
                    d_status = ST_BAD_POS;
                end else if (w_cnt_x >= CMP_W'(LIST_SIZE)) begin
                    d_status = ST_FULL;
                end else if (w_pos_x == w_cnt_x + CMP_W'(1)) begin
                    d_next = S_PUT;
                end else begin
                    // shift up, walking from the top entry down to the slot
                    d_next = S_WALK;
                    d_idx  = w_last;
                    d_end  = w_first;
                end
            end
            CMD_DELETE: begin
                if (w_cnt_x == '0) begin
                    d_status = ST_EMPTY;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                    d_status = ST_BAD_POS;
                end else begin
                    d_next = S_WALK;
                    d_idx  = w_first;
                    d_end  = w_last;
                end
            end
            CMD_GET: begin
                if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                    d_status = ST_BAD_POS;
                end else begin
                    d_next = S_WALK;
                end
            end
            CMD_LOCATE: begin
                d_status = ST_NOT_FOUND;
                if (w_cnt_x != '0) begin
                    d_next = S_WALK;
                    d_idx  = '0;
                    d_end  = w_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = d_next;
                end
            end
            S_WALK: begin
                if (w_hit) begin
                    n_state = S_DONE;
                end else if (r_idx == r_end) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = (r_cmd == CMD_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory port control; returned data is written back in the cycle after its read
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_req.we    = 1'b0;
        w_req.waddr = r_ra;
        w_req.wdata = w_rdata;
        w_req.re    = 1'b0;
        w_req.raddr = r_idx;
        unique case (r_state)
            S_WALK, S_TAIL: begin
                w_req.re = (r_state == S_WALK);
                if (w_proc) begin
                    if (r_cmd == CMD_INSERT) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = r_ra + ADDR_W'(1);
                    end else if (r_cmd == CMD_DELETE && r_ra != r_pos) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = r_ra - ADDR_W'(1);
                    end
                end
            end
            S_PUT: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_pos;
                w_req.wdata = r_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rv        <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= w_req.re;
            if (w_accept && i_command == CMD_CLEAR) begin
                r_count <= '0;
            end else if (r_state == S_PUT) begin
                r_count <= r_count + CNT_W'(1);
            end else if (r_state == S_TAIL && r_cmd == CMD_DELETE) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra <= r_idx;
        if (w_accept) begin
            r_cmd    <= i_command;
            r_pos    <= w_first;
            r_val    <= i_value[DATA_WIDTH-1:0];
            r_idx    <= d_idx;
            r_end    <= d_end;
            r_status <= d_status;
            r_rd     <= '0;
            r_found  <= '0;
        end
        if (r_state == S_WALK) begin
            r_idx <= (r_cmd == CMD_INSERT) ? r_idx - ADDR_W'(1) : r_idx + ADDR_W'(1);
        end
        if (w_proc && (r_cmd == CMD_GET || (r_cmd == CMD_DELETE && r_ra == r_pos))) begin
            r_rd <= w_rdata;
        end
        if (w_hit) begin
            r_found  <= POS_W'(r_ra) + POS_W'(1);
            r_status <= ST_OK;
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_rd     <= VAL_W'(r_rd);
            r_out_found  <= r_found;
            r_out_count  <= COUNT_W'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_read_value     = r_out_rd;
    assign o_found_position = r_out_found;
    assign o_count          = r_out_count;
    assign o_is_empty       = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_SIZE))
        else $error("list length above capacity");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.we && w_req.re) |-> (w_req.waddr != w_req.raddr))
        else $error("read and write of the same entry in one cycle");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second transaction taken while a command is in work");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

endmodule
`default_nettype wire

### test/tb_positional_list_table_core.sv
// Self-checking testbench for the positional list table core.
module tb_positional_list_table_core;
    import plt_pkg::*;

    localparam int SPARE_FIRST = int'(CMD_CLEAR) + 1;
    localparam int SPARE_LAST  = (1 << CMD_W) - 1;
    localparam int DRAIN_WAIT  = LIST_SIZE + 16;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VAL_W-1:0]   read_value;
        logic [POS_W-1:0]   found_position;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_command;
    logic [POS_W-1:0]   i_position;
    logic [VAL_W-1:0]   i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [ST_W-1:0]    o_status;
    logic [VAL_W-1:0]   o_read_value;
    logic [POS_W-1:0]   o_found_position;
    logic [COUNT_W-1:0] o_count;
    logic               o_is_empty;

    // shadow copy of the list
    logic [DATA_WIDTH-1:0] shadow_words [LIST_SIZE];
    int                    shadow_len;

    t_list_result awaited_results[$];
    t_list_result got_result;
    t_list_result want_result;
    int           error_count;
    int           result_index;
    bit           no_idle;
    int           cmd_tally [1 << CMD_W];
    int           status_tally [1 << ST_W];

    positional_list_table_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_count          (o_count),
        .o_is_empty       (o_is_empty)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 45)
            return VAL_W'($urandom_range(0, 7));
        return VAL_W'($urandom);
    endfunction

    // applies one command to the shadow list and returns what the block must report
    function automatic t_list_result predict_list_command(input logic [CMD_W-1:0] cmd,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic [VAL_W-1:0] val);
        t_list_result res;
        int           p;
        int           i;
        p   = int'(pos);
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (p < 1 || p > shadow_len + 1) begin
                    res.status = ST_BAD_POS;
                end else if (shadow_len >= LIST_SIZE) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = shadow_len; i >= p; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p - 1] = val[DATA_WIDTH-1:0];
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.read_value = VAL_W'(shadow_words[p - 1]);
                    for (i = p; i < shadow_len; i++)
                        shadow_words[i - 1] = shadow_words[i];
                    shadow_len--;
                end
            end
            CMD_GET: begin
                if (p < 1 || p > shadow_len)
                    res.status = ST_BAD_POS;
                else
                    res.read_value = VAL_W'(shadow_words[p - 1]);
            end
            CMD_LOCATE: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_words[i] == val[DATA_WIDTH-1:0]) begin
                        res.found_position = POS_W'(i + 1);
                        break;
                    end
                end
                if (res.found_position == '0)
                    res.status = ST_NOT_FOUND;
            end
            CMD_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
            end
        endcase
        res.count    = COUNT_W'(shadow_len);
        res.is_empty = (shadow_len == 0);
        return res;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input int pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_position = POS_W'(pos);
        i_value    = val;
        forever begin
            @(posedge i_clk);
            if (o_in_ready)
                break;
        end
        cmd_tally[cmd]++;
        awaited_results.push_back(predict_list_command(cmd, POS_W'(pos), val));
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR result %0d field %s: got 0x%0h, want 0x%0h",
                 result_index, field, got, want);
        error_count++;
    endtask

    // result side: random stalls on ready
    initial begin
        int stall;
        stall       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = 1'b1;
                stall       = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_result = '{o_status, o_read_value, o_found_position, o_count, o_is_empty};
            if (awaited_results.size() == 0) begin
                $display("ERROR result %0d arrived with nothing outstanding", result_index);
                error_count++;
            end else begin
                want_result = awaited_results.pop_front();
                status_tally[want_result.status]++;
                if (got_result.status !== want_result.status)
                    report_mismatch("status", 64'(got_result.status),
                                    64'(want_result.status));
                if (got_result.read_value !== want_result.read_value)
                    report_mismatch("read_value", 64'(got_result.read_value),
                                    64'(want_result.read_value));
                if (got_result.found_position !== want_result.found_position)
                    report_mismatch("found_position", 64'(got_result.found_position),
                                    64'(want_result.found_position));
                if (got_result.count !== want_result.count)
                    report_mismatch("count", 64'(got_result.count),
                                    64'(want_result.count));
                if (got_result.is_empty !== want_result.is_empty)
                    report_mismatch("is_empty", 64'(got_result.is_empty),
                                    64'(want_result.is_empty));
            end
            result_index++;
        end
    end

    // everything refused or trivial on an empty list, plus the spare codes
    task automatic test_empty_list();
        int c;
        send_command(CMD_GET, 1, '0);
        send_command(CMD_DELETE, 1, '0);
        send_command(CMD_DELETE, 0, '0);
        send_command(CMD_LOCATE, 0, '0);
        send_command(CMD_CLEAR, 0, '0);
        for (c = SPARE_FIRST; c <= SPARE_LAST; c++)
            send_command(CMD_W'(c), $urandom_range(0, 127), VAL_W'($urandom));
    endtask

    task automatic test_position_edges();
        send_command(CMD_INSERT, 0, 32'h1);
        send_command(CMD_INSERT, 2, 32'h1);
        send_command(CMD_INSERT, 1, '0);
        send_command(CMD_INSERT, 2, '1);
        send_command(CMD_INSERT, 1, 32'h5a5a_a5a5);
        send_command(CMD_INSERT, 3, '0);        // duplicate zero in the middle
        send_command(CMD_INSERT, 127, 32'h2);
        send_command(CMD_GET, 0, '0);
        send_command(CMD_GET, shadow_len + 1, '0);
        send_command(CMD_GET, 127, '0);
        send_command(CMD_GET, shadow_len, '0);
        send_command(CMD_LOCATE, 0, '0);        // first of two matches
        send_command(CMD_LOCATE, 0, 32'hdead_beef);
        send_command(CMD_LOCATE, 0, '1);
        send_command(CMD_DELETE, 0, '0);
        send_command(CMD_DELETE, 127, '0);
        send_command(CMD_DELETE, shadow_len + 1, '0);
        send_command(CMD_DELETE, 2, '0);
        send_command(CMD_DELETE, shadow_len, '0);
        send_command(CMD_DELETE, 1, '0);
    endtask

    // grow to capacity, poke the full list, then empty it again
    task automatic test_fill_and_drain();
        send_command(CMD_CLEAR, 0, '0);
        no_idle = 1'b1;
        while (shadow_len < LIST_SIZE)
            send_command(CMD_INSERT, $urandom_range(1, shadow_len + 1), pick_word());
        no_idle = 1'b0;
        send_command(CMD_INSERT, $urandom_range(1, LIST_SIZE + 1), pick_word());
        send_command(CMD_INSERT, 0, pick_word());
        send_command(CMD_INSERT, LIST_SIZE + 2, pick_word());
        send_command(CMD_LOCATE, 0, VAL_W'(shadow_words[LIST_SIZE - 1]));
        send_command(CMD_GET, LIST_SIZE, '0);
        send_command(CMD_DELETE, LIST_SIZE, '0);
        send_command(CMD_INSERT, LIST_SIZE, pick_word());
        while (shadow_len > 0)
            send_command(CMD_DELETE, $urandom_range(1, shadow_len), '0);
        send_command(CMD_DELETE, $urandom_range(0, 127), '0);
    endtask

    function automatic int pick_position(input logic [CMD_W-1:0] cmd);
        int top;
        int r;
        top = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
        r   = $urandom_range(0, 99);
        if (r < 75 && top >= 1)
            return $urandom_range(1, top);
        if (r < 85)
            return top + 1;
        if (r < 90)
            return 0;
        return $urandom_range(0, 127);
    endfunction

    task automatic test_random_mix(input int n_items);
        int               k;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        for (k = 0; k < n_items; k++) begin
            if (k % 100 == 0)
                no_idle = ((k / 100) % 4 == 1);
            r = $urandom_range(0, 99);
            if (r < 40)
                cmd = CMD_INSERT;
            else if (r < 65)
                cmd = CMD_DELETE;
            else if (r < 77)
                cmd = CMD_GET;
            else if (r < 92)
                cmd = CMD_LOCATE;
            else if (r < 95)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(SPARE_FIRST, SPARE_LAST));
            val = pick_word();
            if (cmd == CMD_LOCATE && shadow_len > 0 && $urandom_range(0, 9) < 6)
                val = VAL_W'(shadow_words[$urandom_range(0, shadow_len - 1)]);
            send_command(cmd, pick_position(cmd), val);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_CLEAR;
        i_position   = '0;
        i_value      = '0;
        shadow_len   = 0;
        error_count  = 0;
        result_index = 0;
        no_idle      = 1'b0;
        foreach (cmd_tally[c]) cmd_tally[c] = 0;
        foreach (status_tally[s]) status_tally[s] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_position_edges();
        test_fill_and_drain();
        test_random_mix(380);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered: %0d insert, %0d delete, %0d get, %0d locate, %0d clear, %0d spare",
                 cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE], cmd_tally[CMD_GET],
                 cmd_tally[CMD_LOCATE], cmd_tally[CMD_CLEAR],
                 result_index - cmd_tally[CMD_INSERT] - cmd_tally[CMD_DELETE]
                 - cmd_tally[CMD_GET] - cmd_tally[CMD_LOCATE] - cmd_tally[CMD_CLEAR]);
        $display("outcomes: %0d ok, %0d bad position, %0d full, %0d empty, %0d not found",
                 status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_FULL],
                 status_tally[ST_EMPTY], status_tally[ST_NOT_FOUND]);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
